### rtl/ps2hc_pkg.sv
// package for the two-port ps/2 host controller
// holds item structs, command and phase codes, default constants
// no dependencies
`timescale 1ns / 1ps
package ps2hc_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PORT_COUNT_DEF  = 2;
    localparam logic [7:0] TIMEOUT_RESET = 8'd200;

    typedef enum logic [2:0] {
        CMD_EDGE    = 3'd0,
        CMD_TICK    = 3'd1,
        CMD_SEND    = 3'd2,
        CMD_POP     = 3'd3,
        CMD_INHIBIT = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RX   = 2'd1,
        PH_TX   = 2'd2,
        PH_ACK  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       port;
        logic       data_line;
        logic [7:0] send_byte;
        logic       inhibit_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0] data_low_mask;
        logic [1:0] clock_low_mask;
        logic [7:0] popped_byte;
        logic       rx_available;
        logic       tx_queue_full;
        logic [1:0] port_phase;
        logic       request_to_send;
        logic       timed_out;
    } out_item_t;

endpackage

### rtl/ps2hc_ring_mem.sv
// byte ring storage for both ports, one write and one registered read port
// depends on ps2hc_pkg (default depth)
`timescale 1ns / 1ps
module ps2hc_ring_mem #(
    parameter int DEPTH = ps2hc_pkg::QUEUE_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic          wr_port,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_port,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    import ps2hc_pkg::*;

    // port bit on top of the slot address, so each port owns 2**AW slots
    logic [7:0] mem [0:(2 << AW)-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[{wr_port, wr_addr}] <= wr_data;
        end
        rd_data <= mem[{rd_port, rd_addr}];
    end
endmodule

### rtl/ps2_host_port_controller.sv
// top level of the two-port ps/2 host controller
// depends on ps2hc_pkg and ps2hc_ring_mem
// an item passes the stage-one register, then the output register; the rings are read as it enters stage one
// throughput: one item per cycle while the output is not stalled; the second stage holds the ring read data
// a stalled output register stops both stages together, so the pipe never drops items
// reset (synchronous, aresetn low) idles both ports, empties the rings, limit 200
// ring slots hold no reset value; a slot is only read after it was written
`timescale 1ns / 1ps
module ps2_host_port_controller #(
    parameter int QUEUE_DEPTH = ps2hc_pkg::QUEUE_DEPTH_DEF,
    parameter int PORT_COUNT  = ps2hc_pkg::PORT_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ps2hc_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ps2hc_pkg::out_item_t  m_data
);
    import ps2hc_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

    // per-port control state, in flops
    phase_t     phase_reg   [2];
    logic [3:0] bidx_reg    [2];
    logic [7:0] rshift_reg  [2];
    logic       par_reg     [2];
    logic [7:0] tshift_reg  [2];
    logic [7:0] ticks_reg   [2];
    logic       inh_reg     [2];
    logic       dlow_reg    [2];
    logic       clow_reg    [2];
    logic [AW-1:0] rx_head_reg [2];
    logic [AW-1:0] rx_tail_reg [2];
    logic [AW-1:0] tx_head_reg [2];
    logic [AW-1:0] tx_tail_reg [2];
    logic [7:0] limit_reg;

    // stage one: item captured while the ring read is in flight
    logic     s1_valid_reg;
    in_item_t s1_item_reg;
    logic     adv;

    // output register
    logic      m_valid_reg;
    out_item_t m_data_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ring reads: rx pop reads rx tail, tick reads tx tail; address from the new item
    logic          rd_rx_port, rd_tx_port;
    logic [AW-1:0] rd_rx_addr, rd_tx_addr;
    logic [7:0]    rx_rd_data, tx_rd_data;
    // the tail only moves in stage two, and a hold keeps s1 so reread is fine
    in_item_t      rd_item;
    assign rd_item    = (s_valid && adv) ? s_data : s1_item_reg;

    // stage two computes with the tails after the stage-one item; the
    // stage-one item has not yet updated them when the next one is read,
    // so forward: if stage one pops/starts on the same port, read tail+1
    logic          s2_rx_bump, s2_tx_bump;
    always_comb begin
        rd_rx_port = rd_item.port;
        rd_tx_port = rd_item.port;
        rd_rx_addr = rx_tail_reg[rd_item.port];
        rd_tx_addr = tx_tail_reg[rd_item.port];
        if (adv && s2_rx_bump && s1_item_reg.port == rd_item.port) begin
            rd_rx_addr = (rd_rx_addr == LAST) ? '0 : rd_rx_addr + 1'b1;
        end
        if (adv && s2_tx_bump && s1_item_reg.port == rd_item.port) begin
            rd_tx_addr = (rd_tx_addr == LAST) ? '0 : rd_tx_addr + 1'b1;
        end
    end

    // writes
    logic          rx_we, tx_we;
    logic [AW-1:0] rx_waddr, tx_waddr;
    logic [7:0]    rx_wdata;
    logic          w_port;

    ps2hc_ring_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_rx_ring (
        .aclk(aclk), .wr_en(rx_we), .wr_port(w_port), .wr_addr(rx_waddr),
        .wr_data(rx_wdata), .rd_port(rd_rx_port), .rd_addr(rd_rx_addr),
        .rd_data(rx_rd_data)
    );
    ps2hc_ring_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_tx_ring (
        .aclk(aclk), .wr_en(tx_we), .wr_port(w_port), .wr_addr(tx_waddr),
        .wr_data(s1_item_reg.send_byte), .rd_port(rd_tx_port), .rd_addr(rd_tx_addr),
        .rd_data(tx_rd_data)
    );

    // read-after-write: a byte written last cycle to the slot read now
    logic          fw_rx_hit_reg, fw_tx_hit_reg;
    logic [7:0]    fw_rx_data_reg, fw_tx_data_reg;
    logic [7:0]    rx_byte, tx_byte;
    assign rx_byte = fw_rx_hit_reg ? fw_rx_data_reg : rx_rd_data;
    assign tx_byte = fw_tx_hit_reg ? fw_tx_data_reg : tx_rd_data;

    always_ff @(posedge aclk) begin
        fw_rx_hit_reg  <= rx_we && w_port == rd_rx_port && rx_waddr == rd_rx_addr;
        fw_tx_hit_reg  <= tx_we && w_port == rd_tx_port && tx_waddr == rd_tx_addr;
        fw_rx_data_reg <= rx_wdata;
        fw_tx_data_reg <= s1_item_reg.send_byte;
    end

    // stage two: read-modify-write of the addressed port
    logic       p;
    logic       do_it;
    phase_t     ph_n;
    logic [3:0] bidx_n;
    logic [7:0] rsh_n, tsh_n, tk_n;
    logic       par_n, inh_n, dl_n, cl_n;
    logic [AW-1:0] rxh_n, rxt_n, txh_n, txt_n;
    logic [AW-1:0] rxh_inc, rxt_inc, txh_inc, txt_inc;
    logic       tx_full_n;
    logic [7:0] popped;
    logic       rts, tmo;
    logic       ok;
    logic       d;

    assign p  = s1_item_reg.port;
    assign d  = s1_item_reg.data_line;
    assign ok = (int'(p) < PORT_COUNT);
    assign do_it = s1_valid_reg && adv && ok;
    assign w_port = p;

    always_comb begin
        ph_n   = phase_reg[p];
        bidx_n = bidx_reg[p];
        rsh_n  = rshift_reg[p];
        tsh_n  = tshift_reg[p];
        tk_n   = ticks_reg[p];
        par_n  = par_reg[p];
        inh_n  = inh_reg[p];
        dl_n   = dlow_reg[p];
        cl_n   = clow_reg[p];
        rxh_n  = rx_head_reg[p];
        rxt_n  = rx_tail_reg[p];
        txh_n  = tx_head_reg[p];
        txt_n  = tx_tail_reg[p];
        rxh_inc = (rxh_n == LAST) ? '0 : rxh_n + 1'b1;
        rxt_inc = (rxt_n == LAST) ? '0 : rxt_n + 1'b1;
        txh_inc = (txh_n == LAST) ? '0 : txh_n + 1'b1;
        txt_inc = (txt_n == LAST) ? '0 : txt_n + 1'b1;
        popped = '0;
        rts = 1'b0;
        tmo = 1'b0;
        rx_we = 1'b0;
        tx_we = 1'b0;
        rx_waddr = rxh_n;
        tx_waddr = txh_n;
        rx_wdata = rshift_reg[p];
        s2_rx_bump = 1'b0;
        s2_tx_bump = 1'b0;
        if (s1_valid_reg && ok) begin
            case (s1_item_reg.cmd)
                CMD_EDGE: begin
                    if (!inh_reg[p]) begin
                        tk_n = '0;
                        case (phase_reg[p])
                            PH_IDLE: begin
                                if (!d) begin
                                    ph_n = PH_RX;
                                    bidx_n = '0;
                                    rsh_n = '0;
                                    par_n = 1'b0;
                                end
                            end
                            PH_RX: begin
                                if (bidx_reg[p] < 4'd8) begin
                                    rsh_n = {d, rshift_reg[p][7:1]};
                                    par_n = par_reg[p] ^ d;
                                    bidx_n = bidx_reg[p] + 4'd1;
                                end else if (bidx_reg[p] == 4'd8) begin
                                    par_n = par_reg[p] ^ d;
                                    bidx_n = bidx_reg[p] + 4'd1;
                                end else begin
                                    if (d && par_reg[p] && rxh_inc != rxt_n) begin
                                        rx_we = 1'b1;
                                        rxh_n = rxh_inc;
                                    end
                                    ph_n = PH_IDLE;
                                end
                            end
                            PH_TX: begin
                                if (bidx_reg[p] < 4'd8) begin
                                    dl_n = !tshift_reg[p][0];
                                    tsh_n = {1'b0, tshift_reg[p][7:1]};
                                    par_n = par_reg[p] ^ tshift_reg[p][0];
                                    bidx_n = bidx_reg[p] + 4'd1;
                                end else if (bidx_reg[p] == 4'd8) begin
                                    dl_n = par_reg[p];
                                    bidx_n = bidx_reg[p] + 4'd1;
                                end else if (bidx_reg[p] == 4'd9) begin
                                    dl_n = 1'b0;
                                    bidx_n = bidx_reg[p] + 4'd1;
                                end else begin
                                    ph_n = PH_ACK;
                                end
                            end
                            default: begin
                                dl_n = 1'b0;
                                ph_n = PH_IDLE;
                            end
                        endcase
                    end
                end
                CMD_TICK: begin
                    if (phase_reg[p] != PH_IDLE) begin
                        if (ticks_reg[p] >= limit_reg) begin
                            dl_n = 1'b0;
                            cl_n = 1'b0;
                            ph_n = PH_IDLE;
                            tk_n = '0;
                            tmo = 1'b1;
                        end else begin
                            tk_n = ticks_reg[p] + 8'd1;
                        end
                    end
                    if (ph_n == PH_IDLE && txh_n != txt_n) begin
                        tsh_n = tx_byte;
                        txt_n = txt_inc;
                        s2_tx_bump = 1'b1;
                        par_n = 1'b0;
                        bidx_n = '0;
                        dl_n = 1'b1;
                        cl_n = 1'b0;
                        ph_n = PH_TX;
                        rts = 1'b1;
                    end
                end
                CMD_SEND: begin
                    if (txh_inc != txt_n) begin
                        tx_we = 1'b1;
                        txh_n = txh_inc;
                    end
                end
                CMD_POP: begin
                    if (rxh_n != rxt_n) begin
                        popped = rx_byte;
                        rxt_n = rxt_inc;
                        s2_rx_bump = 1'b1;
                    end
                end
                CMD_INHIBIT: begin
                    inh_n = s1_item_reg.inhibit_value;
                    cl_n = s1_item_reg.inhibit_value;
                end
                default: begin
                end
            endcase
        end
        // full status after the item, with the head as it now stands
        tx_full_n = (((txh_n == LAST) ? '0 : txh_n + 1'b1) == txt_n);
        if (!adv) begin
            rx_we = 1'b0;
            tx_we = 1'b0;
            s2_rx_bump = 1'b0;
            s2_tx_bump = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                phase_reg[i] <= PH_IDLE;
                bidx_reg[i] <= '0;
                rshift_reg[i] <= '0;
                par_reg[i] <= 1'b0;
                tshift_reg[i] <= '0;
                ticks_reg[i] <= '0;
                inh_reg[i] <= 1'b0;
                dlow_reg[i] <= 1'b0;
                clow_reg[i] <= 1'b0;
                rx_head_reg[i] <= '0;
                rx_tail_reg[i] <= '0;
                tx_head_reg[i] <= '0;
                tx_tail_reg[i] <= '0;
            end
            limit_reg <= TIMEOUT_RESET;
            s1_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            if (do_it) begin
                phase_reg[p] <= ph_n;
                bidx_reg[p] <= bidx_n;
                rshift_reg[p] <= rsh_n;
                par_reg[p] <= par_n;
                tshift_reg[p] <= tsh_n;
                ticks_reg[p] <= tk_n;
                inh_reg[p] <= inh_n;
                dlow_reg[p] <= dl_n;
                clow_reg[p] <= cl_n;
                rx_head_reg[p] <= rxh_n;
                rx_tail_reg[p] <= rxt_n;
                tx_head_reg[p] <= txh_n;
                tx_tail_reg[p] <= txt_n;
            end
            if (adv) begin
                s1_valid_reg <= s_valid;
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers
    logic [1:0] dmask, cmask;
    always_comb begin
        dmask = '0;
        cmask = '0;
        for (int q = 0; q < 2; q++) begin
            if (q < PORT_COUNT) begin
                dmask[q] = (do_it && q == int'(p)) ? dl_n : dlow_reg[q];
                cmask[q] = (do_it && q == int'(p)) ? cl_n : clow_reg[q];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_item_reg <= s_data;
            m_data_reg.data_low_mask   <= dmask;
            m_data_reg.clock_low_mask  <= cmask;
            m_data_reg.popped_byte     <= ok ? popped : 8'd0;
            m_data_reg.rx_available    <= ok && (rxh_n != rxt_n);
            m_data_reg.tx_queue_full   <= ok && tx_full_n;
            m_data_reg.port_phase      <= ok ? ph_n : PH_IDLE;
            m_data_reg.request_to_send <= ok && rts;
            m_data_reg.timed_out       <= ok && tmo;
        end
    end
endmodule
